// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the PDU airtime accumulator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bpa_pkg.sv =====
// Package for the PDU airtime accumulator: opcodes, PHY codes, packet field
// sizes in bits, widths and the constant divider used for duty figures.
// No dependencies.
`default_nettype none

package bpa_pkg;

  // Event opcodes carried on the input channel.
  localparam logic [2:0] OP_TX_PDU     = 3'd0;
  localparam logic [2:0] OP_RX_PDU     = 3'd1;
  localparam logic [2:0] OP_CONNECTED  = 3'd2;
  localparam logic [2:0] OP_PHY_UPDATE = 3'd3;
  localparam logic [2:0] OP_SEC_CHANGE = 3'd4;
  localparam logic [2:0] OP_REPORT     = 3'd5;

  // PHY codes; the spare code behaves as 1M.
  localparam logic [1:0] PHY_1M    = 2'd0;
  localparam logic [1:0] PHY_2M    = 2'd1;
  localparam logic [1:0] PHY_CODED = 2'd2;

  // Result kinds.
  localparam logic RK_PDU    = 1'b0;
  localparam logic RK_REPORT = 1'b1;

  // Security levels from this value up mean an encrypted link.
  localparam logic [2:0] SEC_ENC_MIN = 3'd2;

  // Packet field sizes in bits.
  localparam int unsigned PRE_1M_BITS    = 8;
  localparam int unsigned PRE_2M_BITS    = 16;
  localparam int unsigned AA_BITS        = 32;
  localparam int unsigned HDR_BITS       = 16;
  localparam int unsigned CRC_BITS       = 24;
  localparam int unsigned MIC_TAG_BITS   = 32;
  localparam int unsigned TERM_BITS      = 3;
  // Coded PHY: preamble time and FEC block 1 (37 bits at 8 us each).
  localparam int unsigned CODED_PRE_US   = 80;
  localparam int unsigned CODED_FEC1_SYM = 37;
  localparam int unsigned CODED_S8       = 8;

  localparam int unsigned AIR_W  = 15;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned DUTY_W = 19;

  // Duty = airtime / (REPORT_SECONDS * 1000), done as an exact
  // multiply by a rounded-up reciprocal and a right shift.
  localparam int unsigned REPORT_SECONDS = 10;
  localparam longint unsigned DUTY_DIV   = longint'(REPORT_SECONDS) * 1000;
  localparam int unsigned DUTY_SHIFT     = ACC_W + $clog2(DUTY_DIV);
  localparam longint unsigned DUTY_MAGIC =
    ((64'd1 << DUTY_SHIFT) + DUTY_DIV - 64'd1) / DUTY_DIV;
  localparam int unsigned MAGIC_W        = ACC_W + 1;
  localparam longint unsigned DUTY_MAX   = (64'd1 << DUTY_W) - 64'd1;

endpackage

`default_nettype wire

// ===== hdl/ble_pdu_airtime_accumulator_top.sv =====
// Top level of the BLE PDU airtime accumulator: input register, link state,
// saturating totals and result register. Depends on bpa_pkg, bpa_airtime,
// bpa_duty and assert_macros.svh.
//
// Usage: every transfer on the in_ channel is one link event, its opcode in
// in_tuser. TX and RX PDU events each give one result transfer (out_tuser = 0)
// with the packet airtime and add bytes, one packet and the airtime to the
// totals of that direction; every total saturates at 2^32-1. Connected, PHY
// update and security change events only change the link state and give no
// result; a connected or security change event with its error bit set is
// dropped. A report event gives one result (out_tuser = 1) with all six totals,
// the TX and RX duty in tenths of a percent of the report interval and an
// activity flag, and clears the totals. Unused opcodes are dropped.
// The input transfer loads the event into the input register, where the airtime
// or duty logic works on it; the result register loads the result when it is
// free or being drained. One event is taken every cycle as long as the result
// register is empty or is being taken in the same cycle; a stall on out_tready
// holds the result, then fills the input register, and only then drops
// in_tready. After reset the PHYs are 1M, the link is unencrypted, all totals
// are zero and both registers are empty.
`default_nettype none

`include "assert_macros.svh"

module ble_pdu_airtime_accumulator_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [7:0] pdu_length, [9:8] new_tx_phy, [11:10] new_rx_phy,
  // [14:12] security_level, [15] event_error
  input  wire logic [15:0]  in_tdata,
  // [2:0] opcode
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [14:0] PDU airtime in us, [46:15] tx_byte_total, [78:47] tx_packet_total,
  // [110:79] tx_airtime_total, [142:111] rx_byte_total,
  // [174:143] rx_packet_total, [206:175] rx_airtime_total,
  // [225:207] tx_duty_tenths, [244:226] rx_duty_tenths, [245] had_activity,
  // [247:246] zero
  output logic [247:0]      out_tdata,
  // [0] result_kind
  output logic [0:0]        out_tuser
);

  localparam int unsigned AW = bpa_pkg::ACC_W;

  // Input register.
  logic        in_vld_r;
  logic [2:0]  op_r;
  logic [15:0] data_r;

  // Link state and totals.
  logic [1:0]    tx_phy_r, tx_phy_nxt;
  logic [1:0]    rx_phy_r, rx_phy_nxt;
  logic          enc_r, enc_nxt;
  logic [AW-1:0] tx_byte_acc_r, tx_byte_acc_nxt;
  logic [AW-1:0] tx_pkt_acc_r, tx_pkt_acc_nxt;
  logic [AW-1:0] tx_us_acc_r, tx_us_acc_nxt;
  logic [AW-1:0] rx_byte_acc_r, rx_byte_acc_nxt;
  logic [AW-1:0] rx_pkt_acc_r, rx_pkt_acc_nxt;
  logic [AW-1:0] rx_us_acc_r, rx_us_acc_nxt;

  // Result register.
  logic         out_vld_r, out_vld_nxt;
  logic [247:0] out_data_r, out_data_nxt;
  logic         out_kind_r, out_kind_nxt;

  logic pipe_en;
  logic proc_en;

  logic [7:0] len;
  logic [1:0] new_tx_phy;
  logic [1:0] new_rx_phy;
  logic [2:0] sec_level;
  logic       ev_err;

  logic                              is_tx;
  logic [1:0]                        pdu_phy;
  logic [bpa_pkg::AIR_W-1:0]         air_us;
  logic [bpa_pkg::DUTY_W-1:0]        tx_duty;
  logic [bpa_pkg::DUTY_W-1:0]        rx_duty;

  logic [AW:0] byte_sum;
  logic [AW:0] pkt_sum;
  logic [AW:0] us_sum;
  logic [AW-1:0] byte_sat;
  logic [AW-1:0] pkt_sat;
  logic [AW-1:0] us_sat;

  // The pipeline moves whenever the result register is free or being drained.
  assign pipe_en   = !out_vld_r || out_tready;
  assign proc_en   = in_vld_r && pipe_en;
  assign in_tready = !in_vld_r || pipe_en;

  assign len        = data_r[7:0];
  assign new_tx_phy = data_r[9:8];
  assign new_rx_phy = data_r[11:10];
  assign sec_level  = data_r[14:12];
  assign ev_err     = data_r[15];

  assign is_tx   = (op_r == bpa_pkg::OP_TX_PDU);
  assign pdu_phy = is_tx ? tx_phy_r : rx_phy_r;

  bpa_airtime u_airtime (
    .pdu_length (len),
    .phy_mode   (pdu_phy),
    .encrypted  (enc_r),
    .airtime_us (air_us)
  );

  bpa_duty u_tx_duty (
    .airtime_total (tx_us_acc_r),
    .duty_tenths   (tx_duty)
  );

  bpa_duty u_rx_duty (
    .airtime_total (rx_us_acc_r),
    .duty_tenths   (rx_duty)
  );

  // One shared set of saturating adders serves whichever direction the PDU is on.
  assign byte_sum = {1'b0, (is_tx ? tx_byte_acc_r : rx_byte_acc_r)} +
                    {{(AW - 7){1'b0}}, len};
  assign pkt_sum  = {1'b0, (is_tx ? tx_pkt_acc_r : rx_pkt_acc_r)} + (AW + 1)'(1);
  assign us_sum   = {1'b0, (is_tx ? tx_us_acc_r : rx_us_acc_r)} +
                    {{(AW + 1 - bpa_pkg::AIR_W){1'b0}}, air_us};
  assign byte_sat = byte_sum[AW] ? '1 : byte_sum[AW-1:0];
  assign pkt_sat  = pkt_sum[AW]  ? '1 : pkt_sum[AW-1:0];
  assign us_sat   = us_sum[AW]   ? '1 : us_sum[AW-1:0];

  // Next link state and totals.
  always_comb begin
    tx_phy_nxt      = tx_phy_r;
    rx_phy_nxt      = rx_phy_r;
    enc_nxt         = enc_r;
    tx_byte_acc_nxt = tx_byte_acc_r;
    tx_pkt_acc_nxt  = tx_pkt_acc_r;
    tx_us_acc_nxt   = tx_us_acc_r;
    rx_byte_acc_nxt = rx_byte_acc_r;
    rx_pkt_acc_nxt  = rx_pkt_acc_r;
    rx_us_acc_nxt   = rx_us_acc_r;
    if (proc_en) begin
      unique case (op_r)
        bpa_pkg::OP_TX_PDU: begin
          tx_byte_acc_nxt = byte_sat;
          tx_pkt_acc_nxt  = pkt_sat;
          tx_us_acc_nxt   = us_sat;
        end
        bpa_pkg::OP_RX_PDU: begin
          rx_byte_acc_nxt = byte_sat;
          rx_pkt_acc_nxt  = pkt_sat;
          rx_us_acc_nxt   = us_sat;
        end
        bpa_pkg::OP_CONNECTED: begin
          if (!ev_err) begin
            tx_phy_nxt = bpa_pkg::PHY_1M;
            rx_phy_nxt = bpa_pkg::PHY_1M;
            enc_nxt    = 1'b0;
          end
        end
        bpa_pkg::OP_PHY_UPDATE: begin
          tx_phy_nxt = new_tx_phy;
          rx_phy_nxt = new_rx_phy;
        end
        bpa_pkg::OP_SEC_CHANGE: begin
          if (!ev_err) begin
            enc_nxt = (sec_level >= bpa_pkg::SEC_ENC_MIN);
          end
        end
        bpa_pkg::OP_REPORT: begin
          tx_byte_acc_nxt = '0;
          tx_pkt_acc_nxt  = '0;
          tx_us_acc_nxt   = '0;
          rx_byte_acc_nxt = '0;
          rx_pkt_acc_nxt  = '0;
          rx_us_acc_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Next result register contents.
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_kind_nxt = out_kind_r;
    if (pipe_en) begin
      out_vld_nxt = 1'b0;
      if (in_vld_r) begin
        priority if (op_r == bpa_pkg::OP_TX_PDU || op_r == bpa_pkg::OP_RX_PDU) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = bpa_pkg::RK_PDU;
          out_data_nxt = {233'd0, air_us};
        end else if (op_r == bpa_pkg::OP_REPORT) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = bpa_pkg::RK_REPORT;
          out_data_nxt = {2'b00,
                          (tx_pkt_acc_r != '0) || (rx_pkt_acc_r != '0),
                          rx_duty, tx_duty,
                          rx_us_acc_r, rx_pkt_acc_r, rx_byte_acc_r,
                          tx_us_acc_r, tx_pkt_acc_r, tx_byte_acc_r,
                          {bpa_pkg::AIR_W{1'b0}}};
        end else begin
          out_vld_nxt = 1'b0;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      tx_phy_r      <= bpa_pkg::PHY_1M;
      rx_phy_r      <= bpa_pkg::PHY_1M;
      enc_r         <= 1'b0;
      tx_byte_acc_r <= '0;
      tx_pkt_acc_r  <= '0;
      tx_us_acc_r   <= '0;
      rx_byte_acc_r <= '0;
      rx_pkt_acc_r  <= '0;
      rx_us_acc_r   <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      out_vld_r     <= out_vld_nxt;
      tx_phy_r      <= tx_phy_nxt;
      rx_phy_r      <= rx_phy_nxt;
      enc_r         <= enc_nxt;
      tx_byte_acc_r <= tx_byte_acc_nxt;
      tx_pkt_acc_r  <= tx_pkt_acc_nxt;
      tx_us_acc_r   <= tx_us_acc_nxt;
      rx_byte_acc_r <= rx_byte_acc_nxt;
      rx_pkt_acc_r  <= rx_pkt_acc_nxt;
      rx_us_acc_r   <= rx_us_acc_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= in_tuser;
      data_r <= in_tdata;
    end
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_kind_r;

  // A stalled result with an occupied input register must close the input.
  `BPA_ASSERT_NOW(a_stall_blocks_input, out_vld_r && !out_tready && in_vld_r, !in_tready, "input accepted while both registers are held")
  // A report leaves every packet total at zero.
  `BPA_ASSERT_NEXT(a_report_clears, proc_en && op_r == bpa_pkg::OP_REPORT, tx_pkt_acc_r == '0 && rx_pkt_acc_r == '0, "totals not cleared by report")
  // A report never carries a per-PDU airtime.
  `BPA_ASSERT_NOW(a_report_no_air, out_vld_r && out_kind_r == bpa_pkg::RK_REPORT, out_data_r[bpa_pkg::AIR_W-1:0] == '0, "report carries PDU airtime")
  // The shortest packet on any PHY lasts at least 44 us.
  `BPA_ASSERT_NOW(a_pdu_air_min, out_vld_r && out_kind_r == bpa_pkg::RK_PDU, out_data_r[bpa_pkg::AIR_W-1:0] >= 15'd44, "PDU airtime below minimum packet length")

endmodule

`default_nettype wire

// ===== hdl/bpa_airtime.sv =====
// Packet airtime in microseconds for one PDU on the 1M, 2M or Coded (S=8) PHY.
// Depends on bpa_pkg.
`default_nettype none

module bpa_airtime (
  input  wire logic [7:0]                    pdu_length,
  input  wire logic [1:0]                    phy_mode,
  input  wire logic                          encrypted,
  output logic      [bpa_pkg::AIR_W-1:0]     airtime_us
);

  localparam logic [bpa_pkg::AIR_W-1:0] BASE_1M = bpa_pkg::AIR_W'(
    bpa_pkg::PRE_1M_BITS + bpa_pkg::AA_BITS + bpa_pkg::HDR_BITS + bpa_pkg::CRC_BITS);
  localparam logic [bpa_pkg::AIR_W-1:0] BASE_2M = bpa_pkg::AIR_W'(
    bpa_pkg::PRE_2M_BITS + bpa_pkg::AA_BITS + bpa_pkg::HDR_BITS + bpa_pkg::CRC_BITS);
  // Coded: preamble, FEC block 1, then FEC block 2 bits (header, CRC, TERM2) at S=8.
  localparam logic [bpa_pkg::AIR_W-1:0] BASE_CODED = bpa_pkg::AIR_W'(
    bpa_pkg::CODED_PRE_US + bpa_pkg::CODED_FEC1_SYM * bpa_pkg::CODED_S8 +
    (bpa_pkg::HDR_BITS + bpa_pkg::CRC_BITS + bpa_pkg::TERM_BITS) * bpa_pkg::CODED_S8);

  logic [bpa_pkg::AIR_W-1:0] payload_bits;
  logic [bpa_pkg::AIR_W-1:0] mic_len;
  logic [bpa_pkg::AIR_W-1:0] bits_2m;

  assign payload_bits = {4'd0, pdu_length, 3'd0};
  assign mic_len      = encrypted ? bpa_pkg::AIR_W'(bpa_pkg::MIC_TAG_BITS) : '0;
  assign bits_2m      = BASE_2M + payload_bits + mic_len;

  always_comb begin
    unique case (phy_mode)
      bpa_pkg::PHY_2M: begin
        airtime_us = {1'b0, bits_2m[bpa_pkg::AIR_W-1:1]};
      end
      bpa_pkg::PHY_CODED: begin
        airtime_us = BASE_CODED + {payload_bits[bpa_pkg::AIR_W-4:0], 3'd0} +
                     {mic_len[bpa_pkg::AIR_W-4:0], 3'd0};
      end
      default: begin
        airtime_us = BASE_1M + payload_bits + mic_len;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/bpa_duty.sv =====
// Duty in tenths of a percent: airtime total divided by the report interval in ms,
// by reciprocal multiplication, saturated to the result width. Depends on bpa_pkg.
`default_nettype none

module bpa_duty (
  input  wire logic [bpa_pkg::ACC_W-1:0]  airtime_total,
  output logic      [bpa_pkg::DUTY_W-1:0] duty_tenths
);

  localparam int unsigned PROD_W = bpa_pkg::ACC_W + bpa_pkg::MAGIC_W;

  logic [bpa_pkg::MAGIC_W-1:0] magic;
  logic [PROD_W-1:0]           product;
  logic [PROD_W-1:0]           quotient;

  assign magic    = bpa_pkg::DUTY_MAGIC[bpa_pkg::MAGIC_W-1:0];
  assign product  = {{bpa_pkg::MAGIC_W{1'b0}}, airtime_total} *
                    {{bpa_pkg::ACC_W{1'b0}}, magic};
  assign quotient = product >> bpa_pkg::DUTY_SHIFT;

  always_comb begin
    if (quotient > PROD_W'(bpa_pkg::DUTY_MAX)) begin
      duty_tenths = '1;
    end else begin
      duty_tenths = quotient[bpa_pkg::DUTY_W-1:0];
    end
  end

endmodule

`default_nettype wire
